// File: sv/trmm_pkg.sv
package trmm_pkg;

    // default sizes of the value tables
    localparam int DEPTH_DEF       = 1024;
    localparam int VALUE_WIDTH_DEF = 32;

    // fixed field widths
    localparam int OP_W     = 1;
    localparam int SEL_W    = 1;
    localparam int IDX_W    = 10;
    localparam int DATA_W   = 32;
    localparam int HI_W     = 11;
    localparam int LEN_W    = 11;
    localparam int TOTAL_W  = 12;

    // input word layout, lowest bit first
    localparam int IN_WIDX_LSB = 0;
    localparam int IN_WVAL_LSB = IN_WIDX_LSB + IDX_W;
    localparam int IN_LOA_LSB  = IN_WVAL_LSB + DATA_W;
    localparam int IN_HIA_LSB  = IN_LOA_LSB + IDX_W;
    localparam int IN_LOB_LSB  = IN_HIA_LSB + HI_W;
    localparam int IN_HIB_LSB  = IN_LOB_LSB + IDX_W;
    localparam int IN_USED_W   = IN_HIB_LSB + HI_W;
    localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;
    localparam int IN_TUSER_W  = OP_W + SEL_W;
    localparam int OUT_TDATA_W = DATA_W;
    localparam int OUT_TUSER_W = 1;

    // operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // table selector codes
    localparam logic SEL_A = 1'b0;
    localparam logic SEL_B = 1'b1;

    // status codes
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    // number of elements in an inclusive range, zero when hi is below lo
    function automatic logic [LEN_W-1:0] range_len(
        input logic        [IDX_W-1:0] lo,
        input logic signed [HI_W-1:0]  hi
    );
        logic signed [TOTAL_W-1:0] diff;
        diff = TOTAL_W'(hi) - $signed({2'b00, lo});
        if (diff < 0)
        begin
            return '0;
        end
        return LEN_W'(diff + TOTAL_W'(1));
    endfunction

endpackage

// File: sv/trmm_ram.sv
module trmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: sv/two_range_merge_median_top.sv
// Write word: index reduction (REDUCE), then the table write (WRITE); the next word is taken back in IDLE.
// Query word: index reduction, then ceil(total/2) merge steps, then FIN, which holds while
// a previous result waits; the next word can be taken once the result is valid.
// Each merge step is one table read (READ) plus one compare (CMP), as the RAM read is registered.
// Reset (rst_n low, asynchronous) empties the result register and returns to idle;
// table contents are undefined until written.
module two_range_merge_median_top #(
    parameter int DEPTH       = trmm_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = trmm_pkg::VALUE_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // write_index, write_value, lo_a, hi_a, lo_b, hi_b, zero pad
    input  logic [trmm_pkg::IN_TDATA_W-1:0]    s_tdata,
    // op, table_sel
    input  logic [trmm_pkg::IN_TUSER_W-1:0]    s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // median
    output logic [trmm_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // status
    output logic [trmm_pkg::OUT_TUSER_W-1:0]   m_tuser
);

    localparam int AW      = $clog2(DEPTH);
    localparam int IDX_W   = trmm_pkg::IDX_W;
    localparam int LEN_W   = trmm_pkg::LEN_W;
    localparam int TOTAL_W = trmm_pkg::TOTAL_W;
    localparam int DATA_W  = trmm_pkg::DATA_W;
    localparam int HI_W    = trmm_pkg::HI_W;

    // reciprocal constants for index mod DEPTH, exact for every index value
    localparam int RED_D  = (DEPTH < (1 << IDX_W)) ? DEPTH : (1 << IDX_W);
    localparam int RED_SH = IDX_W + $clog2(RED_D);
    localparam int RED_M  = ((1 << RED_SH) + RED_D - 1) / RED_D;
    localparam int RED_W  = 2 * IDX_W + 2;

    typedef enum logic [2:0] {
        IDLE,
        REDUCE,
        WRITE,
        READ,
        CMP,
        FIN
    } state_t;

    state_t                         state_reg, state_next;
    logic                           op_reg, op_next;
    logic                           sel_reg, sel_next;
    logic signed [VALUE_WIDTH-1:0]  wval_reg, wval_next;
    logic [IDX_W-1:0]               r0_reg, r0_next;
    logic [IDX_W-1:0]               r1_reg, r1_next;
    logic [LEN_W-1:0]               rem_a_reg, rem_a_next;
    logic [LEN_W-1:0]               rem_b_reg, rem_b_next;
    logic [AW-1:0]                  ptr_a_reg, ptr_a_next;
    logic [AW-1:0]                  ptr_b_reg, ptr_b_next;
    logic [LEN_W-1:0]               left_reg, left_next;
    logic signed [VALUE_WIDTH-1:0]  pick_reg, pick_next;
    logic                           empty_reg, empty_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0]              median_reg, median_next;
    logic                           status_reg, status_next;

    logic [IDX_W-1:0]               r0_red, r1_red;
    logic [TOTAL_W-1:0]             total;
    logic signed [VALUE_WIDTH-1:0]  rd_a, rd_b;
    logic                           take_a;
    logic                           we_a, we_b;
    logic [AW-1:0]                  addr_a, addr_b;
    logic [AW-1:0]                  wptr;

    // input field views
    logic [IDX_W-1:0]               in_widx, in_lo_a, in_lo_b;
    logic signed [DATA_W-1:0]       in_wval;
    logic signed [HI_W-1:0]         in_hi_a, in_hi_b;

    assign in_widx = s_tdata[trmm_pkg::IN_WIDX_LSB +: IDX_W];
    assign in_wval = $signed(s_tdata[trmm_pkg::IN_WVAL_LSB +: DATA_W]);
    assign in_lo_a = s_tdata[trmm_pkg::IN_LOA_LSB +: IDX_W];
    assign in_hi_a = $signed(s_tdata[trmm_pkg::IN_HIA_LSB +: HI_W]);
    assign in_lo_b = s_tdata[trmm_pkg::IN_LOB_LSB +: IDX_W];
    assign in_hi_b = $signed(s_tdata[trmm_pkg::IN_HIB_LSB +: HI_W]);

    // index mod DEPTH: quotient by reciprocal multiply, then one subtract
    function automatic logic [IDX_W-1:0] idx_mod(input logic [IDX_W-1:0] idx);
        logic [RED_W-1:0] prod;
        logic [RED_W-1:0] quot;
        prod = RED_W'(idx) * RED_W'(RED_M);
        quot = prod >> RED_SH;
        return IDX_W'(RED_W'(idx) - quot * RED_W'(RED_D));
    endfunction

    assign r0_red = idx_mod(r0_reg);
    assign r1_red = idx_mod(r1_reg);

    assign total = TOTAL_W'(rem_a_reg) + TOTAL_W'(rem_b_reg);

    // merge decision on the heads read last cycle
    always_comb
    begin
        if (rem_a_reg == '0)
        begin
            take_a = 1'b0;
        end
        else if (rem_b_reg == '0)
        begin
            take_a = 1'b1;
        end
        else
        begin
            take_a = rd_a < rd_b;
        end
    end

    // table ports
    assign wptr   = AW'(r0_reg);
    assign we_a   = (state_reg == WRITE) && (sel_reg == trmm_pkg::SEL_A);
    assign we_b   = (state_reg == WRITE) && (sel_reg == trmm_pkg::SEL_B);
    assign addr_a = (state_reg == WRITE) ? wptr : ptr_a_reg;
    assign addr_b = (state_reg == WRITE) ? wptr : ptr_b_reg;

    trmm_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .clk   (clk),
        .we    (we_a),
        .addr  (addr_a),
        .wdata (wval_reg),
        .rdata (rd_a)
    );

    trmm_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .clk   (clk),
        .we    (we_b),
        .addr  (addr_b),
        .wdata (wval_reg),
        .rdata (rd_b)
    );

    // next state and datapath
    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        sel_next      = sel_reg;
        wval_next     = wval_reg;
        r0_next       = r0_reg;
        r1_next       = r1_reg;
        rem_a_next    = rem_a_reg;
        rem_b_next    = rem_b_reg;
        ptr_a_next    = ptr_a_reg;
        ptr_b_next    = ptr_b_reg;
        left_next     = left_reg;
        pick_next     = pick_reg;
        empty_next    = empty_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        median_next   = median_reg;
        status_next   = status_reg;

        unique case (state_reg)
            IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = s_tuser[0];
                    sel_next   = s_tuser[1];
                    wval_next  = VALUE_WIDTH'(in_wval);
                    r0_next    = (s_tuser[0] == trmm_pkg::OP_WRITE) ? in_widx : in_lo_a;
                    r1_next    = in_lo_b;
                    rem_a_next = trmm_pkg::range_len(in_lo_a, in_hi_a);
                    rem_b_next = trmm_pkg::range_len(in_lo_b, in_hi_b);
                    state_next = REDUCE;
                end
            end
            REDUCE:
            begin
                r0_next    = r0_red;
                r1_next    = r1_red;
                ptr_a_next = AW'(r0_red);
                ptr_b_next = AW'(r1_red);
                left_next  = LEN_W'((total + TOTAL_W'(1)) >> 1);
                pick_next  = '0;
                empty_next = (total == '0);
                if (op_reg == trmm_pkg::OP_WRITE)
                begin
                    state_next = WRITE;
                end
                else if (total == '0)
                begin
                    state_next = FIN;
                end
                else
                begin
                    state_next = READ;
                end
            end
            WRITE:
            begin
                state_next = IDLE;
            end
            READ:
            begin
                state_next = CMP;
            end
            CMP:
            begin
                if (take_a)
                begin
                    pick_next  = rd_a;
                    rem_a_next = LEN_W'(rem_a_reg - 1'b1);
                    ptr_a_next = (ptr_a_reg == AW'(DEPTH - 1)) ? '0 : AW'(ptr_a_reg + 1'b1);
                end
                else
                begin
                    pick_next  = rd_b;
                    rem_b_next = LEN_W'(rem_b_reg - 1'b1);
                    ptr_b_next = (ptr_b_reg == AW'(DEPTH - 1)) ? '0 : AW'(ptr_b_reg + 1'b1);
                end
                left_next  = LEN_W'(left_reg - 1'b1);
                state_next = (left_reg == LEN_W'(1)) ? FIN : READ;
            end
            FIN:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    median_next   = DATA_W'(pick_reg);
                    status_next   = empty_reg ? trmm_pkg::STATUS_EMPTY : trmm_pkg::STATUS_OK;
                    state_next    = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= IDLE;
            m_tvalid_reg <= 1'b0;
            op_reg       <= 1'b0;
            sel_reg      <= 1'b0;
            wval_reg     <= '0;
            r0_reg       <= '0;
            r1_reg       <= '0;
            rem_a_reg    <= '0;
            rem_b_reg    <= '0;
            ptr_a_reg    <= '0;
            ptr_b_reg    <= '0;
            left_reg     <= '0;
            pick_reg     <= '0;
            empty_reg    <= 1'b0;
            median_reg   <= '0;
            status_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            op_reg       <= op_next;
            sel_reg      <= sel_next;
            wval_reg     <= wval_next;
            r0_reg       <= r0_next;
            r1_reg       <= r1_next;
            rem_a_reg    <= rem_a_next;
            rem_b_reg    <= rem_b_next;
            ptr_a_reg    <= ptr_a_next;
            ptr_b_reg    <= ptr_b_next;
            left_reg     <= left_next;
            pick_reg     <= pick_next;
            empty_reg    <= empty_next;
            median_reg   <= median_next;
            status_reg   <= status_next;
        end
    end

    assign s_tready   = (state_reg == IDLE);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = median_reg;
    assign m_tuser[0] = status_reg;

`ifndef NO_ASSERTIONS
    // an empty query reports a zero median
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser[0] == trmm_pkg::STATUS_EMPTY)) |-> (m_tdata == '0))
        else $error("empty status with nonzero median");

    // a merge step always has a range left to take from
    a_cmp_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CMP) |-> ((rem_a_reg != '0) || (rem_b_reg != '0)))
        else $error("merge step with both ranges exhausted");

    // a read is only issued while merge steps remain
    a_read_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == READ) |-> (left_reg != '0))
        else $error("table read with no merge steps left");

    // a result is loaded only when the output register is free
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == FIN) && m_tvalid && !m_tready) |=> (state_reg == FIN))
        else $error("result left finish while output stalled");
`endif

endmodule

// File: tb/tb_two_range_merge_median_top.sv
`timescale 1ns / 1ps

module tb_two_range_merge_median_top;

    localparam int TBL_N     = trmm_pkg::DEPTH_DEF;
    localparam int N_WORDS   = 580;
    localparam int DRAIN_CYC = 2100;
    localparam int IDX_W     = trmm_pkg::IDX_W;
    localparam int DATA_W    = trmm_pkg::DATA_W;
    localparam int HI_W      = trmm_pkg::HI_W;

    // one input word, unpacked by field
    typedef struct {
        logic                     op;
        logic                     sel;
        logic [IDX_W-1:0]         widx;
        logic [DATA_W-1:0]        wval;
        logic [IDX_W-1:0]         lo_a;
        logic signed [HI_W-1:0]   hi_a;
        logic [IDX_W-1:0]         lo_b;
        logic signed [HI_W-1:0]   hi_b;
    } trmm_word_t;

    // one result word
    typedef struct {
        logic [DATA_W-1:0] median;
        logic              status;
    } median_res_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    // write_index, write_value, lo_a, hi_a, lo_b, hi_b, zero pad
    logic [trmm_pkg::IN_TDATA_W-1:0]     s_tdata = '0;
    // op, table_sel
    logic [trmm_pkg::IN_TUSER_W-1:0]     s_tuser = '0;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    // median
    logic [trmm_pkg::OUT_TDATA_W-1:0]    m_tdata;
    // status
    logic [trmm_pkg::OUT_TUSER_W-1:0]    m_tuser;

    two_range_merge_median_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // pending words and expected medians
    trmm_word_t  pend_q[$];
    median_res_t median_exp_q[$];

    // predictor copy of both value tables
    logic [DATA_W-1:0] tab_a [TBL_N];
    logic [DATA_W-1:0] tab_b [TBL_N];

    // entries already written by the generated stimulus
    bit gen_wr_a [TBL_N];
    bit gen_wr_b [TBL_N];

    int         n_words;
    int         err_cnt;
    longint     cyc_budget;
    longint     cyc_limit = 64'h7fff_ffff_ffff;
    longint     cyc_cnt;
    trmm_word_t drv_cur;
    int         burst_left;
    int         gap_left;
    int         rcv_tick;
    int         rcv_mode;

    // clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    // element count of an inclusive range, zero when hi is below lo
    function automatic int span_len(int lo, int hi);
        return (hi < lo) ? 0 : hi - lo + 1;
    endfunction

    // lower median of the merged ranges
    function automatic median_res_t merge_median(trmm_word_t w);
        median_res_t r;
        int          len_a;
        int          len_b;
        int          total;
        int          steps;
        int          na;
        int          nb;
        int          s;
        logic [DATA_W-1:0] va;
        logic [DATA_W-1:0] vb;
        bit          take_a;
        len_a = span_len(int'(w.lo_a), int'(w.hi_a));
        len_b = span_len(int'(w.lo_b), int'(w.hi_b));
        total = len_a + len_b;
        r.median = '0;
        r.status = trmm_pkg::STATUS_EMPTY;
        if (total == 0)
            return r;
        r.status = trmm_pkg::STATUS_OK;
        na = 0;
        nb = 0;
        steps = (total + 1) / 2;
        for (s = 0; s < steps; s++)
        begin
            va = tab_a[(int'(w.lo_a) + na) % TBL_N];
            vb = tab_b[(int'(w.lo_b) + nb) % TBL_N];
            // a drained range hands over to the other, ties go to b
            if (na >= len_a)
                take_a = 1'b0;
            else if (nb >= len_b)
                take_a = 1'b1;
            else
                take_a = ($signed(va) < $signed(vb));
            if (take_a)
            begin
                r.median = va;
                na++;
            end
            else
            begin
                r.median = vb;
                nb++;
            end
        end
        return r;
    endfunction

    // update tables or queue the expected median
    task automatic apply_word(trmm_word_t w);
        if (w.op == trmm_pkg::OP_WRITE)
        begin
            if (w.sel == trmm_pkg::SEL_B)
                tab_b[w.widx] = w.wval;
            else
                tab_a[w.widx] = w.wval;
        end
        else
        begin
            median_exp_q.push_back(merge_median(w));
        end
    endtask

    function automatic logic [trmm_pkg::IN_TDATA_W-1:0] pack_word(trmm_word_t w);
        logic [trmm_pkg::IN_TDATA_W-1:0] d;
        d = '0;
        d[trmm_pkg::IN_WIDX_LSB +: IDX_W]  = w.widx;
        d[trmm_pkg::IN_WVAL_LSB +: DATA_W] = w.wval;
        d[trmm_pkg::IN_LOA_LSB +: IDX_W]   = w.lo_a;
        d[trmm_pkg::IN_HIA_LSB +: HI_W]    = w.hi_a;
        d[trmm_pkg::IN_LOB_LSB +: IDX_W]   = w.lo_b;
        d[trmm_pkg::IN_HIB_LSB +: HI_W]    = w.hi_b;
        return d;
    endfunction

    function automatic bit gen_written(logic sel, int idx);
        return (sel == trmm_pkg::SEL_B) ? gen_wr_b[idx % TBL_N] : gen_wr_a[idx % TBL_N];
    endfunction

    // longest range from lo whose entries past lo, and the one after the range, are all written
    function automatic int avail_len(logic sel, int lo);
        int n;
        n = 0;
        while (n < TBL_N - lo && gen_written(sel, lo + n + 1))
            n++;
        return n;
    endfunction

    // an hi anywhere from the field minimum up to lo - 1
    function automatic int far_below(int lo);
        return int'($urandom_range(0, lo + TBL_N - 1)) - TBL_N;
    endfunction

    task automatic push_write(logic sel, int idx, logic [DATA_W-1:0] val);
        trmm_word_t w;
        w.op   = trmm_pkg::OP_WRITE;
        w.sel  = sel;
        w.widx = IDX_W'(idx);
        w.wval = val;
        // query fields carry noise on a write
        w.lo_a = IDX_W'($urandom);
        w.hi_a = HI_W'($urandom);
        w.lo_b = IDX_W'($urandom);
        w.hi_b = HI_W'($urandom);
        if (sel == trmm_pkg::SEL_B)
            gen_wr_b[idx % TBL_N] = 1'b1;
        else
            gen_wr_a[idx % TBL_N] = 1'b1;
        pend_q.push_back(w);
        n_words++;
        cyc_budget += 24;
    endtask

    task automatic push_query(int lo_a, int hi_a, int lo_b, int hi_b);
        trmm_word_t w;
        w.op   = trmm_pkg::OP_QUERY;
        // write fields carry noise on a query
        w.sel  = 1'($urandom);
        w.widx = IDX_W'($urandom);
        w.wval = $urandom;
        w.lo_a = IDX_W'(lo_a);
        w.hi_a = HI_W'(hi_a);
        w.lo_b = IDX_W'(lo_b);
        w.hi_b = HI_W'(hi_b);
        pend_q.push_back(w);
        n_words++;
        cyc_budget += 100 + span_len(lo_a, hi_a) + span_len(lo_b, hi_b);
    endtask

    // non-decreasing run of n + 1 values starting at base
    task automatic write_run(logic sel, int base, int n, bit tight_vals);
        longint v;
        int     i;
        if (tight_vals)
            v = longint'($urandom_range(0, 16)) - 8;
        else if ($urandom_range(0, 5) == 0)
            v = -64'sd2147483648;
        else
            v = longint'(int'($urandom));
        for (i = 0; i <= n; i++)
        begin
            push_write(sel, (base + i) % TBL_N, DATA_W'(v));
            if (tight_vals)
                v += $urandom_range(0, 2);
            else
            begin
                case ($urandom_range(0, 3))
                    1, 2: v += $urandom_range(1, 1000);
                    3:    v += longint'($urandom);
                    default: v += 0;
                endcase
            end
            if (v > 64'sd2147483647)
                v = 64'sd2147483647;
        end
    endtask

    // sorted sub-range inside a freshly written run
    task automatic pick_in_run(logic sel, int base, int n, output int lo, output int hi);
        int off;
        int cap;
        int len;
        off = $urandom_range(0, n);
        lo = (base + off) % TBL_N;
        cap = n - off;
        if (avail_len(sel, lo) < cap)
            cap = avail_len(sel, lo);
        len = ($urandom_range(0, 2) == 0) ? cap : int'($urandom_range(0, cap));
        hi = lo + len - 1;
        if ($urandom_range(0, 11) == 0)
            hi = far_below(lo);
    endtask

    // range over any written entries, sorted or not
    task automatic pick_any(logic sel, int cap_max, output int lo, output int hi);
        int cap;
        lo = $urandom_range(0, TBL_N - 1);
        while (!gen_written(sel, lo))
            lo = (lo + 1) % TBL_N;
        cap = avail_len(sel, lo);
        if (cap > cap_max)
            cap = cap_max;
        hi = lo + int'($urandom_range(0, cap)) - 1;
    endtask

    // stimulus, reset and end of run
    initial
    begin : stim_main
        int kind;
        int na;
        int nb;
        int base_a;
        int base_b;
        int lo_a;
        int hi_a;
        int lo_b;
        int hi_b;
        bit tight_vals;

        // extreme values at both ends of each table
        push_write(trmm_pkg::SEL_A, 0, 32'h8000_0000);
        push_write(trmm_pkg::SEL_A, 1, DATA_W'(-5));
        push_write(trmm_pkg::SEL_A, 2, 7);
        push_write(trmm_pkg::SEL_A, 3, 9);
        push_write(trmm_pkg::SEL_A, 1022, 100);
        push_write(trmm_pkg::SEL_A, 1023, 32'h7fff_ffff);
        push_write(trmm_pkg::SEL_B, 0, DATA_W'(-5));
        push_write(trmm_pkg::SEL_B, 1, 0);
        push_write(trmm_pkg::SEL_B, 2, 32'h7fff_ffff);
        push_write(trmm_pkg::SEL_B, 3, 32'h7fff_ffff);
        push_write(trmm_pkg::SEL_B, 1022, 2);
        push_write(trmm_pkg::SEL_B, 1023, 32'hffff_ffff);

        // both empty, also with hi at the field minimum
        push_query(0, -1, 0, -1);
        push_query(1023, -1024, 1023, -1024);
        // one side empty
        push_query(0, 2, 1, 0);
        push_query(0, -1, 0, 2);
        // equal heads take b first
        push_query(0, 2, 0, 2);
        // last entries, next index wraps to zero
        push_query(1023, 1023, 1023, 1023);
        push_query(1022, 1023, 1, 2);
        // signed extremes against each other
        push_query(0, 0, 2, 2);
        // a runs dry early
        push_query(0, 0, 0, 2);

        // random sequences, mostly sorted runs followed by queries
        while (n_words < N_WORDS)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 6)
            begin
                tight_vals = 1'($urandom);
                na = ($urandom_range(0, 11) == 0) ? $urandom_range(30, 120)
                                                  : $urandom_range(0, 12);
                nb = ($urandom_range(0, 11) == 0) ? $urandom_range(30, 120)
                                                  : $urandom_range(0, 12);
                base_a = $urandom_range(0, TBL_N - 1);
                base_b = $urandom_range(0, TBL_N - 1);
                write_run(trmm_pkg::SEL_A, base_a, na, tight_vals);
                write_run(trmm_pkg::SEL_B, base_b, nb, tight_vals);
                repeat ($urandom_range(2, 5))
                begin
                    pick_in_run(trmm_pkg::SEL_A, base_a, na, lo_a, hi_a);
                    pick_in_run(trmm_pkg::SEL_B, base_b, nb, lo_b, hi_b);
                    push_query(lo_a, hi_a, lo_b, hi_b);
                end
            end
            else if (kind == 7)
            begin
                // stray writes that may break earlier runs
                repeat ($urandom_range(1, 4))
                    push_write(1'($urandom), $urandom_range(0, TBL_N - 1), $urandom);
            end
            else if (kind == 8)
            begin
                repeat (2)
                begin
                    pick_any(trmm_pkg::SEL_A, 24, lo_a, hi_a);
                    pick_any(trmm_pkg::SEL_B, 24, lo_b, hi_b);
                    push_query(lo_a, hi_a, lo_b, hi_b);
                end
            end
            else
            begin
                // empty ranges with hi well below lo
                pick_any(trmm_pkg::SEL_A, 8, lo_a, hi_a);
                pick_any(trmm_pkg::SEL_B, 8, lo_b, hi_b);
                case ($urandom_range(0, 2))
                    0: hi_a = far_below(lo_a);
                    1: hi_b = far_below(lo_b);
                    default:
                    begin
                        hi_a = far_below(lo_a);
                        hi_b = far_below(lo_b);
                    end
                endcase
                push_query(lo_a, hi_a, lo_b, hi_b);
            end
        end
        cyc_limit = 4 * cyc_budget + 30000 + DRAIN_CYC;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // wait for all words sent and all medians returned
        while (pend_q.size() != 0 || s_tvalid || median_exp_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYC) @(negedge clk);

        if (err_cnt == 0 && median_exp_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // input driver, bursts with random gaps
    always @(posedge clk or negedge rst_n)
    begin : word_driver
        logic nv;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            nv = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                apply_word(drv_cur);
                nv = 1'b0;
            end
            if (!nv)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (pend_q.size() > 0)
                begin
                    drv_cur = pend_q.pop_front();
                    s_tdata <= pack_word(drv_cur);
                    s_tuser <= {drv_cur.sel, drv_cur.op};
                    nv = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        // end of burst: pick the gap and the next burst length
                        if ($urandom_range(0, 5) == 0)
                        begin
                            gap_left   = 0;
                            burst_left = $urandom_range(40, 80);
                        end
                        else
                        begin
                            gap_left   = ($urandom_range(0, 2) == 0) ? 0
                                                                     : $urandom_range(1, 8);
                            burst_left = $urandom_range(1, 16);
                        end
                    end
                end
            end
            s_tvalid <= nv;
        end
    end

    // result monitor and receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin : median_monitor
        median_res_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rcv_tick <= 0;
            rcv_mode <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (median_exp_q.size() == 0)
                begin
                    if (err_cnt < 10)
                        $display("unexpected result word: median %h status %b",
                                 m_tdata, m_tuser);
                    err_cnt++;
                end
                else
                begin
                    want = median_exp_q.pop_front();
                    if (m_tdata !== want.median || m_tuser[0] !== want.status)
                    begin
                        if (err_cnt < 10)
                            $display("mismatch: median exp %h got %h, status exp %b got %b",
                                     want.median, m_tdata, want.status, m_tuser);
                        err_cnt++;
                    end
                end
            end

            // stall mode is redrawn at random as rcv_tick counts
            rcv_tick <= rcv_tick + 1;
            if (rcv_tick % 64 == 63)
                rcv_mode <= $urandom_range(0, 3);
            case (rcv_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom);
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= (rcv_tick % 32) >= 20;
            endcase
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt > cyc_limit)
        begin
            $display("status: fail");
            $finish;
        end
    end

endmodule
